>>> hdl/boxsm_pkg.sv
package boxsm_pkg;

   localparam int PIX_W      = 8;
   localparam int SUM_W      = 12;
   localparam int SIDE_CFG_W = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int RECIP_W    = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_SIDE = 2'd0;
   localparam logic [SIDE_CFG_W-1:0] SIDE_RESET     = 5'd2;

   // floor(x / d) == (x * RECIP) >> RECIP_W for every window sum
   localparam logic [RECIP_W-1:0] RECIP4 = 16'd16384;
   localparam logic [RECIP_W-1:0] RECIP6 = 16'd10923;
   localparam logic [RECIP_W-1:0] RECIP9 = 16'd7282;

   typedef enum logic [1:0] {
      DIV_4,
      DIV_6,
      DIV_9
   } div_type;

   function automatic div_type div_sel(input logic rows3, input logic cols3);
      div_type d;
      if (rows3 && cols3) begin
         d = DIV_9;
      end else if (rows3 || cols3) begin
         d = DIV_6;
      end else begin
         d = DIV_4;
      end
      return d;
   endfunction

endpackage

>>> hdl/box_smoothing_3x3.sv
// 3x3 box smoothing of a square frame (side 2..MAX_SIDE, set by frame_side at
// csr address 0; writing it restarts the frame) streamed in raster order. Each
// smoothed pixel is the truncated mean of its in-bounds neighbors (divide by 4,
// 6 or 9) and comes out tagged with its row and column, one row and one pixel
// behind the input. One pixel is taken per clock unless stalled; results leave
// through a single-result emitter, one per clock unless the output stalls. A
// pixel ending a row below the first causes two results, each pixel in the last
// row past its first column two and the last pixel four. The extra results at
// row and frame ends overlap the pixels that follow, which cause none, so with
// the output free only a pixel in the last row holds the input back. Results
// pass stage 1, the result list, the divider input and the output register.
// The two MAX_SIDE-entry line stores are read when a pixel is taken and written
// back when it leaves the first stage; they need no clearing after reset.
module box_smoothing_3x3 #(
   parameter int MAX_SIDE = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [boxsm_pkg::PIX_W-1:0]              req_pixel,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [boxsm_pkg::PIX_W-1:0]              rsp_smoothed,
   output logic [$clog2(MAX_SIDE)-1:0]              rsp_out_row,
   output logic [$clog2(MAX_SIDE)-1:0]              rsp_out_col,
   output logic                                     rsp_run_last,
   output logic                                     rsp_frame_done,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [boxsm_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [boxsm_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [boxsm_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                     csr_pready
);

   localparam int CoordW = $clog2(MAX_SIDE);
   localparam int SideW  = $clog2(MAX_SIDE + 1);
   localparam int PixW   = boxsm_pkg::PIX_W;
   localparam int SumW   = boxsm_pkg::SUM_W;
   localparam int Col3W  = PixW + 2;
   localparam int Col2W  = PixW + 1;
   localparam int ProdW  = SumW + boxsm_pkg::RECIP_W;

   typedef struct packed {
      logic [SumW-1:0]     sum;
      boxsm_pkg::div_type  div;
      logic [CoordW-1:0]   row;
      logic [CoordW-1:0]   col;
      logic                run_last;
      logic                frame_done;
   } entry_type;

   // configuration
   logic [boxsm_pkg::SIDE_CFG_W-1:0] frame_side_ff;
   logic [SideW-1:0]                 side_eff;
   logic [SideW-1:0]                 side_m1;
   logic                             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == boxsm_pkg::CSR_FRAME_SIDE);
   assign csr_prdata = (csr_paddr == boxsm_pkg::CSR_FRAME_SIDE)
                       ? boxsm_pkg::CSR_DATA_W'(frame_side_ff) : '0;

   always_comb begin
      if (frame_side_ff < boxsm_pkg::SIDE_CFG_W'(2)) begin
         side_eff = SideW'(2);
      end else if (int'(frame_side_ff) > MAX_SIDE) begin
         side_eff = SideW'(MAX_SIDE);
      end else begin
         side_eff = SideW'(frame_side_ff);
      end
   end
   assign side_m1 = side_eff - SideW'(1);

   // handshake and pipeline control
   logic accept;
   logic v1_ff, v2_ff, v3_ff, out_v_ff;
   logic s1_go, s2_free, s3_free, out_free, emit, has_res;
   logic [1:0] idx_ff, last_ff, last_in;

   assign out_free  = !out_v_ff || rsp_ready;
   assign s3_free   = !v3_ff || out_free;
   assign emit      = v2_ff && s3_free;
   assign s2_free   = !v2_ff || (emit && (idx_ff == last_ff));
   assign s1_go     = v1_ff && (!has_res || s2_free);
   assign req_ready = !v1_ff || s1_go;
   assign accept    = req_valid && req_ready;

   // position counters
   logic [CoordW-1:0] in_row_ff, in_col_ff, in_row_in, in_col_in;

   always_comb begin
      in_row_in = in_row_ff;
      in_col_in = in_col_ff + CoordW'(1);
      if (SideW'(in_col_ff) == side_m1) begin
         in_col_in = '0;
         if (SideW'(in_row_ff) == side_m1) begin
            in_row_in = '0;
         end else begin
            in_row_in = in_row_ff + CoordW'(1);
         end
      end
   end

   // line stores
   logic [PixW-1:0] upper_mem  [MAX_SIDE];
   logic [PixW-1:0] middle_mem [MAX_SIDE];
   logic [PixW-1:0] up_rd_ff, mid_rd_ff;

   // stage 1 payload
   logic [PixW-1:0]   pix1_ff;
   logic [CoordW-1:0] r1_ff, c1_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff  <= upper_mem[in_col_ff];
         mid_rd_ff <= middle_mem[in_col_ff];
         pix1_ff   <= req_pixel;
         r1_ff     <= in_row_ff;
         c1_ff     <= in_col_ff;
      end
      if (s1_go) begin
         upper_mem[c1_ff]  <= mid_rd_ff;
         middle_mem[c1_ff] <= pix1_ff;
      end
   end

   // column sums and sliding window (cols c-2, c-1)
   logic [Col3W-1:0] col3, w3_ff [2];
   logic [Col2W-1:0] col2, w2_ff [2];
   logic             last_col1, last_row1, rows3, cols3;
   logic [SumW-1:0]  a3, a2, b3, b2, n3, n2;
   logic [SumW-1:0]  sum_x, sum_y, sum_z, sum_w;
   entry_type        ent_x, ent_y, ent_z, ent_w;
   entry_type        list_in [4];
   entry_type        list_ff [4];
   entry_type        e3_ff;

   assign col3 = Col3W'(up_rd_ff) + Col3W'(mid_rd_ff) + Col3W'(pix1_ff);
   assign col2 = Col2W'(mid_rd_ff) + Col2W'(pix1_ff);

   assign has_res   = (r1_ff != '0) && (c1_ff != '0);
   assign last_col1 = (SideW'(c1_ff) == side_m1);
   assign last_row1 = (SideW'(r1_ff) == side_m1);
   assign rows3     = (r1_ff != CoordW'(1));
   assign cols3     = (c1_ff != CoordW'(1));

   assign a3 = cols3 ? SumW'(rows3 ? w3_ff[0] : Col3W'(w2_ff[0])) : '0;
   assign b3 = SumW'(rows3 ? w3_ff[1] : Col3W'(w2_ff[1]));
   assign n3 = SumW'(rows3 ? col3 : Col3W'(col2));
   assign a2 = cols3 ? SumW'(w2_ff[0]) : '0;
   assign b2 = SumW'(w2_ff[1]);
   assign n2 = SumW'(col2);

   assign sum_x = a3 + b3 + n3;
   assign sum_y = b3 + n3;
   assign sum_z = a2 + b2 + n2;
   assign sum_w = b2 + n2;

   always_comb begin
      ent_x = '{sum: sum_x, div: boxsm_pkg::div_sel(rows3, cols3),
                row: r1_ff - CoordW'(1), col: c1_ff - CoordW'(1),
                run_last: 1'b0, frame_done: 1'b0};
      ent_y = '{sum: sum_y, div: boxsm_pkg::div_sel(rows3, 1'b0),
                row: r1_ff - CoordW'(1), col: c1_ff,
                run_last: 1'b0, frame_done: 1'b0};
      ent_z = '{sum: sum_z, div: boxsm_pkg::div_sel(1'b0, cols3),
                row: r1_ff, col: c1_ff - CoordW'(1),
                run_last: 1'b0, frame_done: 1'b0};
      ent_w = '{sum: sum_w, div: boxsm_pkg::DIV_4,
                row: r1_ff, col: c1_ff,
                run_last: 1'b1, frame_done: 1'b1};
      list_in[0] = ent_x;
      list_in[1] = ent_x;
      list_in[2] = ent_z;
      list_in[3] = ent_w;
      unique case ({last_col1, last_row1})
         2'b00: begin
            list_in[0].run_last = 1'b1;
            last_in = 2'd0;
         end
         2'b10: begin
            ent_y.run_last = 1'b1;
            list_in[1] = ent_y;
            last_in = 2'd1;
         end
         2'b01: begin
            ent_z.run_last = 1'b1;
            list_in[1] = ent_z;
            last_in = 2'd1;
         end
         2'b11: begin
            list_in[1] = ent_y;
            last_in = 2'd3;
         end
         default: begin
            last_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         w3_ff[0] <= w3_ff[1];
         w3_ff[1] <= col3;
         w2_ff[0] <= w2_ff[1];
         w2_ff[1] <= col2;
      end
      if (s1_go && has_res) begin
         list_ff <= list_in;
         last_ff <= last_in;
      end
      if (emit) begin
         e3_ff <= list_ff[idx_ff];
      end
   end

   // divide by 4, 6 or 9 through a reciprocal
   logic [boxsm_pkg::RECIP_W-1:0] recip;
   logic [ProdW-1:0]              prod;

   always_comb begin
      unique case (e3_ff.div)
         boxsm_pkg::DIV_4: recip = boxsm_pkg::RECIP4;
         boxsm_pkg::DIV_6: recip = boxsm_pkg::RECIP6;
         boxsm_pkg::DIV_9: recip = boxsm_pkg::RECIP9;
         default:          recip = boxsm_pkg::RECIP9;
      endcase
   end
   assign prod = ProdW'(e3_ff.sum) * ProdW'(recip);

   logic [PixW-1:0]   smoothed_ff;
   logic [CoordW-1:0] out_row_ff, out_col_ff;
   logic              run_last_ff, frame_done_ff;

   always_ff @(posedge clock) begin
      if (v3_ff && out_free) begin
         smoothed_ff   <= prod[boxsm_pkg::RECIP_W +: PixW];
         out_row_ff    <= e3_ff.row;
         out_col_ff    <= e3_ff.col;
         run_last_ff   <= e3_ff.run_last;
         frame_done_ff <= e3_ff.frame_done;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_smoothed   = smoothed_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_frame_done = frame_done_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_side_ff <= boxsm_pkg::SIDE_RESET;
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         out_v_ff      <= 1'b0;
         idx_ff        <= '0;
      end else begin
         if (csr_wr) begin
            frame_side_ff <= csr_pwdata[boxsm_pkg::SIDE_CFG_W-1:0];
            in_row_ff     <= '0;
            in_col_ff     <= '0;
         end else if (accept) begin
            in_row_ff <= in_row_in;
            in_col_ff <= in_col_in;
         end

         if (accept) begin
            v1_ff <= 1'b1;
         end else if (s1_go) begin
            v1_ff <= 1'b0;
         end

         if (s1_go && has_res) begin
            v2_ff  <= 1'b1;
            idx_ff <= '0;
         end else if (s2_free) begin
            v2_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= idx_ff + 2'd1;
         end

         if (emit) begin
            v3_ff <= 1'b1;
         end else if (out_free) begin
            v3_ff <= 1'b0;
         end

         if (v3_ff && out_free) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (idx_ff <= last_ff))
      else $error("emitter index past last result");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> rsp_run_last)
      else $error("frame done without run last");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> v1_ff)
      else $error("request stalled with stage one empty");

   a_load_after_go: assert property (@(posedge clock) disable iff (reset)
      (s1_go && has_res) |=> v2_ff)
      else $error("result job lost");

endmodule

>>> test/tb_box_smoothing_3x3.sv
module tb_box_smoothing_3x3;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIX_W      = boxsm_pkg::PIX_W;
   localparam int CSR_ADDR_W = boxsm_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = boxsm_pkg::CSR_DATA_W;
   localparam int SIDE_CFG_W = boxsm_pkg::SIDE_CFG_W;

   localparam int SIDE_MAX   = 16;
   localparam int SETTLE     = 8;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_PIXELS = 66;

   typedef struct packed {
      logic [PIX_W-1:0] smoothed;
      logic [3:0]       row;
      logic [3:0]       col;
      logic             run_last;
      logic             frame_done;
   } smooth_res_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_pixel   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [PIX_W-1:0]      rsp_smoothed;
   logic [3:0]            rsp_out_row;
   logic [3:0]            rsp_out_col;
   logic                  rsp_run_last;
   logic                  rsp_frame_done;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [PIX_W-1:0]      upper_q  [SIDE_MAX];
   logic [PIX_W-1:0]      middle_q [SIDE_MAX];
   logic [PIX_W-1:0]      current_q[SIDE_MAX];
   int unsigned           row_q = 0;
   int unsigned           col_q = 0;
   logic [SIDE_CFG_W-1:0] side_reg = boxsm_pkg::SIDE_RESET;

   smooth_res_type        pending_q[$];
   smooth_res_type        head;
   int unsigned           fail_count = 0;
   int unsigned           quiet_cycles = 0;
   logic                  no_gaps = 1'b0;

   box_smoothing_3x3 #(.MAX_SIDE(SIDE_MAX)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_smoothed   (rsp_smoothed),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned side_used();
      int unsigned s;
      s = 32'(side_reg);
      if (s < 2) s = 2;
      if (s > SIDE_MAX) s = SIDE_MAX;
      return s;
   endfunction

   // mean of the in-bounds 3x3 neighborhood of (r, c); rows are taken relative to row_q
   function automatic smooth_res_type window_mean(input int unsigned r, input int unsigned c,
                                                  input int unsigned s);
      int unsigned r0, r1, c0, c1, sum, cnt;
      smooth_res_type res;
      r0  = (r == 0) ? 0 : r - 1;
      r1  = (r + 1 >= s) ? s - 1 : r + 1;
      c0  = (c == 0) ? 0 : c - 1;
      c1  = (c + 1 >= s) ? s - 1 : c + 1;
      sum = 0;
      cnt = 0;
      for (int unsigned x = r0; x <= r1; x++) begin
         for (int unsigned y = c0; y <= c1; y++) begin
            if (x == row_q) sum += 32'(current_q[y]);
            else if (x + 1 == row_q) sum += 32'(middle_q[y]);
            else sum += 32'(upper_q[y]);
            cnt++;
         end
      end
      res.smoothed   = PIX_W'(sum / cnt);
      res.row        = 4'(r);
      res.col        = 4'(c);
      res.run_last   = 1'b0;
      res.frame_done = 1'b0;
      return res;
   endfunction

   function automatic void predict_pixel(input logic [PIX_W-1:0] px);
      int unsigned s, r, c, n;
      smooth_res_type res[4];
      s = side_used();
      r = row_q;
      c = col_q;
      if (r >= s || c >= s) begin
         r = 0;
         c = 0;
         row_q = 0;
         col_q = 0;
      end
      current_q[c] = px;
      n = 0;
      if (r >= 1 && c >= 1) begin
         res[n] = window_mean(r - 1, c - 1, s);
         n++;
         if (c == s - 1) begin
            res[n] = window_mean(r - 1, s - 1, s);
            n++;
         end
      end
      if (r == s - 1 && c >= 1) begin
         res[n] = window_mean(s - 1, c - 1, s);
         n++;
         if (c == s - 1) begin
            res[n] = window_mean(s - 1, s - 1, s);
            res[n].frame_done = 1'b1;
            n++;
         end
      end
      if (n > 0) res[n-1].run_last = 1'b1;
      for (int unsigned k = 0; k < n; k++) pending_q.push_back(res[k]);
      c++;
      if (c >= s) begin
         c = 0;
         upper_q  = middle_q;
         middle_q = current_q;
         r++;
         if (r >= s) r = 0;
      end
      row_q = r;
      col_q = c;
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] px);
      while (!no_gaps && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!req_ready);
      predict_pixel(px);
   endtask

   // block idle: every expected result in, then room for pixels that cause none
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_frame_side(input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= boxsm_pkg::CSR_FRAME_SIDE;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      side_reg = value[SIDE_CFG_W-1:0];
      row_q = 0;
      col_q = 0;
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) return '0;
      if (pick < 16) return '1;
      return PIX_W'($urandom);
   endfunction

   function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
                                       input logic [PIX_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_ready <= no_gaps || ($urandom_range(99) >= 9);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            $error("unexpected result at row %0d col %0d", rsp_out_row, rsp_out_col);
            fail_count++;
         end else begin
            head = pending_q.pop_front();
            check_field("smoothed", head.smoothed, rsp_smoothed);
            check_field("out_row", PIX_W'(head.row), PIX_W'(rsp_out_row));
            check_field("out_col", PIX_W'(head.col), PIX_W'(rsp_out_col));
            check_field("run_last", PIX_W'(head.run_last), PIX_W'(rsp_run_last));
            check_field("frame_done", PIX_W'(head.frame_done), PIX_W'(rsp_frame_done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_box_smoothing_3x3: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // side 2 straight out of reset, no register write
   task automatic test_default_side();
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd255);
      settle();
   endtask

   // side 3: corners, edges and the full 3x3 case
   task automatic test_small_extremes();
      logic [PIX_W-1:0] pix[9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                   8'd0, 8'd255, 8'd170, 8'd85};
      write_frame_side(32'd3);
      foreach (pix[i]) send_pixel(pix[i]);
      settle();
   endtask

   // partial frame, then a write restarts counters; side 0 acts as 2
   task automatic test_midframe_restart();
      write_frame_side(32'd5);
      repeat (7) send_pixel(random_pixel());
      settle();
      write_frame_side(32'd0);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd128);
      send_pixel(8'd1);
      settle();
   endtask

   task automatic test_low_clamp();
      write_frame_side(32'd1);
      send_pixel(8'd0);
      send_pixel(8'd0);
      send_pixel(8'd0);
      send_pixel(8'd255);
      settle();
   endtask

   // side 31 acts as the maximum; upper data bits are don't-care
   task automatic test_max_side();
      logic [CSR_DATA_W-1:0] value;
      value = $urandom;
      value[SIDE_CFG_W-1:0] = 5'd31;
      write_frame_side(value);
      no_gaps = 1'b1;
      repeat (SIDE_MAX * SIDE_MAX) send_pixel(random_pixel());
      settle();
      no_gaps = 1'b0;
   endtask

   task automatic test_random_frames();
      int unsigned sent, pick, s, len;
      logic [CSR_DATA_W-1:0] value;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         if ($urandom_range(99) < 65) begin
            settle();
            pick = $urandom_range(99);
            value = ($urandom_range(3) == 0) ? $urandom : '0;
            if (pick < 75) value[SIDE_CFG_W-1:0] = 5'($urandom_range(6, 2));
            else if (pick < 85) value[SIDE_CFG_W-1:0] = 5'($urandom_range(1, 0));
            else if (pick < 97) value[SIDE_CFG_W-1:0] = 5'($urandom_range(15, 7));
            else value[SIDE_CFG_W-1:0] = 5'($urandom_range(31, 16));
            write_frame_side(value);
         end
         s = side_used();
         len = s * s;
         if ($urandom_range(99) < 12) len = $urandom_range(s * s - 1, 1);
         if (len > RANDOM_PIXELS - sent) len = RANDOM_PIXELS - sent;
         repeat (len) send_pixel(random_pixel());
         sent += len;
      end
      settle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_side();
      test_small_extremes();
      test_midframe_restart();
      test_low_clamp();
      test_max_side();
      test_random_frames();
      if (fail_count == 0) begin
         $display("tb_box_smoothing_3x3: PASS");
      end else begin
         $display("tb_box_smoothing_3x3: FAIL");
      end
      $finish;
   end

endmodule
